// ----- rtl/core/pnae_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnae_pkg
// Shared types and constants of the pad note and aftertouch engine: command
// and message codes, decoded operation entries, result and register types.
// ----------------------------------------------------------------------------
package pnae_pkg;

   // field widths of the stream beats
   localparam int CMD_W      = 3;
   localparam int PAD_W      = 5;
   localparam int NOTE_IN_W  = 8;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int PRES_W     = 7;
   localparam int BEND_W     = 14;
   localparam int TIME_W     = 32;
   localparam int KIND_W     = 2;
   localparam int CHAN_W     = 4;
   localparam int VALUE_W    = 14;
   localparam int INTERVAL_W = 8;
   localparam int STEP_W     = 7;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - CHAN_W - NOTE_W - VALUE_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // unmapped note marker
   localparam logic [NOTE_IN_W-1:0] NOTE_NONE = 8'hFF;

   // request commands
   localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PRESSURE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ALL_OFF  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BEND     = 3'd5;

   // message kinds on the response side
   localparam logic [KIND_W-1:0] MSG_NOTE  = 2'd0;
   localparam logic [KIND_W-1:0] MSG_AFTER = 2'd1;
   localparam logic [KIND_W-1:0] MSG_BEND  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MIDI_CHANNEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INTERVAL     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_MIN     = 2'd2;

   // register reset values
   localparam logic [CHAN_W-1:0]     CHANNEL_RESET  = 4'd0;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd25;
   localparam logic [STEP_W-1:0]     STEP_RESET     = 7'd4;

   // decoded operations carried through the queue
   typedef enum logic [2:0] {
      OP_NOTE_ON  = 3'd0,
      OP_NOTE_OFF = 3'd1,
      OP_PRESSURE = 3'd2,
      OP_FLUSH    = 3'd3,
      OP_ALL_OFF  = 3'd4,
      OP_BEND     = 3'd5
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [PAD_W-1:0]    pad;
      logic [NOTE_W-1:0]   note;
      logic [VALUE_W-1:0]  value;
      logic [TIME_W-1:0]   now;
   } op_entry_type;

   typedef struct packed {
      logic [CHAN_W-1:0]     channel;
      logic [INTERVAL_W-1:0] interval;
      logic [STEP_W-1:0]     step_min;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAN_W-1:0]  channel;
      logic [NOTE_W-1:0]  note;
      logic [VALUE_W-1:0] value;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic [PRES_W-1:0] pressure;
   } ring_entry_type;

endpackage

// ----- rtl/core/pnae_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnae_front
// Request side: takes beats, drops items that cannot have any effect and
// turns the rest into compact operation entries for the queue.
// ----------------------------------------------------------------------------
module pnae_front
   import pnae_pkg::*;
#(
   parameter int PAD_COUNT = 32
) (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [CMD_W-1:0]       req_tuser,
   input  logic                   q_full,
   output logic                   q_push,
   output op_entry_type           q_entry
);

   localparam logic [PAD_W+1:0] PAD_LIMIT = (PAD_W + 2)'(PAD_COUNT);

   logic [PAD_W-1:0]     pad;
   logic [NOTE_IN_W-1:0] note_number;
   logic [VEL_W-1:0]     velocity;
   logic [PRES_W-1:0]    pressure;
   logic [BEND_W-1:0]    bend_value;
   logic [TIME_W-1:0]    now_ms;
   logic                 pad_ok;
   logic                 keep;

   // unpack the beat
   assign pad         = req_tdata[4:0];
   assign note_number = req_tdata[12:5];
   assign velocity    = req_tdata[19:13];
   assign pressure    = req_tdata[26:20];
   assign bend_value  = req_tdata[40:27];
   assign now_ms      = req_tdata[72:41];

   assign pad_ok     = (PAD_W + 2)'(pad) < PAD_LIMIT;
   assign req_tready = !q_full;

   // classify the command
   always_comb begin
      keep            = 1'b0;
      q_entry.op      = OP_FLUSH;
      q_entry.pad     = pad;
      q_entry.note    = note_number[NOTE_W-1:0];
      q_entry.value   = '0;
      q_entry.now     = now_ms;
      case (req_tuser)
         CMD_NOTE_ON: begin
            keep          = pad_ok && (note_number != NOTE_NONE);
            q_entry.op    = OP_NOTE_ON;
            q_entry.value = VALUE_W'(velocity);
         end
         CMD_NOTE_OFF: begin
            keep       = pad_ok;
            q_entry.op = OP_NOTE_OFF;
         end
         CMD_PRESSURE: begin
            keep          = pad_ok;
            q_entry.op    = OP_PRESSURE;
            q_entry.value = VALUE_W'(pressure);
         end
         CMD_FLUSH: begin
            keep       = 1'b1;
            q_entry.op = OP_FLUSH;
         end
         CMD_ALL_OFF: begin
            keep       = 1'b1;
            q_entry.op = OP_ALL_OFF;
         end
         CMD_BEND: begin
            keep          = 1'b1;
            q_entry.op    = OP_BEND;
            q_entry.value = VALUE_W'(bend_value);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = req_tvalid && req_tready && keep;

endmodule

// ----- rtl/core/pnae_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnae_fifo
// Short queue of decoded operations between the front and the back end.
// ----------------------------------------------------------------------------
module pnae_fifo
   import pnae_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  op_entry_type  push_data,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output op_entry_type  head_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   op_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/pnae_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnae_back
// Execution side: owns the per-pad tables and the aftertouch ring, runs one
// operation at a time and drives the response register.
// ----------------------------------------------------------------------------
module pnae_back
   import pnae_pkg::*;
#(
   parameter int PAD_COUNT   = 32,
   parameter int RING_DEPTH  = 16,
   parameter int FLUSH_LIMIT = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          q_valid,
   input  op_entry_type  q_data,
   output logic          q_pop,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_type       rsp
);

   localparam int PAD_IW  = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
   localparam int RING_IW = $clog2(RING_DEPTH);
   localparam int CNT_W   = $clog2(FLUSH_LIMIT + 1);
   localparam logic [RING_IW-1:0] RING_LAST = RING_IW'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(FLUSH_LIMIT - 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_OFF   = 7'b0000010,
      ST_PRES  = 7'b0000100,
      ST_FRD   = 7'b0001000,
      ST_FEMIT = 7'b0010000,
      ST_ARD   = 7'b0100000,
      ST_AEMIT = 7'b1000000
   } back_state_type;

   back_state_type       st_ff, st_in;
   op_entry_type         op_ff, op_in;
   logic [PAD_COUNT-1:0] active_ff, active_in;
   logic [PAD_COUNT-1:0] seen_ff, seen_in;
   logic [RING_IW-1:0]   head_ff, head_in;
   logic [RING_IW-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PAD_IW-1:0]    sel_ff, sel_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;

   // pad tables and ring
   logic [NOTE_W-1:0]  note_mem [PAD_COUNT];
   logic [PRES_W-1:0]  pres_mem [PAD_COUNT];
   logic [TIME_W-1:0]  time_mem [PAD_COUNT];
   ring_entry_type     ring_mem [RING_DEPTH];

   logic [NOTE_W-1:0]  note_rd_ff;
   logic [PRES_W-1:0]  pres_rd_ff;
   logic [TIME_W-1:0]  time_rd_ff;
   logic               seen_rd_ff;
   ring_entry_type     ring_rd_ff;

   logic [PAD_IW-1:0]    q_pidx, op_pidx, first_idx, note_raddr, wr_addr;
   logic                 out_free;
   logic                 note_re, pad_re, ring_re;
   logic                 note_we, pres_we, time_we, ring_we;
   logic [NOTE_W-1:0]    note_wdata;
   logic [PRES_W-1:0]    pres_wdata;
   logic [PRES_W-1:0]    new_pres;
   logic [PRES_W-1:0]    delta;
   logic [TIME_W-1:0]    sent_time;
   logic [TIME_W-1:0]    elapsed;
   logic [RING_IW-1:0]   head_next, tail_next;
   logic                 at_pass;
   logic                 flush_last;
   logic [PAD_COUNT-1:0] remain;
   logic                 all_off_last;
   logic                 emit;
   rsp_type              emit_rsp;

   assign q_pidx   = PAD_IW'(q_data.pad);
   assign op_pidx  = PAD_IW'(op_ff.pad);
   assign out_free = !out_valid_ff || rsp_ready;

   // lowest active pad for the all-off walk
   always_comb begin
      first_idx = '0;
      for (int i = PAD_COUNT - 1; i >= 0; i--) begin
         if (active_ff[i]) begin
            first_idx = PAD_IW'(i);
         end
      end
   end

   // last pad of the all-off walk once the selected one is cleared
   always_comb begin
      remain         = active_ff;
      remain[sel_ff] = 1'b0;
   end
   assign all_off_last = (remain == '0);

   // aftertouch qualification
   assign new_pres  = op_ff.value[PRES_W-1:0];
   assign delta     = (new_pres >= pres_rd_ff) ? new_pres - pres_rd_ff
                                               : pres_rd_ff - new_pres;
   assign sent_time = seen_rd_ff ? time_rd_ff : '0;
   assign elapsed   = op_ff.now - sent_time;
   assign head_next = (head_ff == RING_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == RING_LAST) ? '0 : tail_ff + 1'b1;
   assign at_pass   = (delta >= cfg.step_min)
                   && (elapsed >= TIME_W'(cfg.interval))
                   && (head_next != tail_ff);
   assign flush_last = (cnt_ff == CNT_LAST) || (tail_next == head_ff);

   // table port selection
   assign note_re    = (st_ff == ST_IDLE) || (st_ff == ST_ARD);
   assign pad_re     = (st_ff == ST_IDLE);
   assign ring_re    = (st_ff == ST_FRD);
   assign note_raddr = (st_ff == ST_ARD) ? first_idx : q_pidx;
   assign wr_addr    = (st_ff == ST_IDLE) ? q_pidx : op_pidx;

   // sequencer
   always_comb begin
      st_in      = st_ff;
      op_in      = op_ff;
      active_in  = active_ff;
      seen_in    = seen_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      cnt_in     = cnt_ff;
      sel_in     = sel_ff;
      q_pop      = 1'b0;
      note_we    = 1'b0;
      pres_we    = 1'b0;
      time_we    = 1'b0;
      ring_we    = 1'b0;
      note_wdata = q_data.note;
      pres_wdata = '0;
      emit       = 1'b0;
      emit_rsp.kind    = MSG_NOTE;
      emit_rsp.channel = cfg.channel;
      emit_rsp.note    = '0;
      emit_rsp.value   = '0;
      emit_rsp.last    = 1'b1;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               op_in = q_data;
               case (q_data.op)
                  OP_NOTE_ON: begin
                     if (out_free) begin
                        q_pop             = 1'b1;
                        note_we           = 1'b1;
                        pres_we           = 1'b1;
                        active_in[q_pidx] = 1'b1;
                        emit              = 1'b1;
                        emit_rsp.note     = q_data.note;
                        emit_rsp.value    = q_data.value;
                     end
                  end
                  OP_BEND: begin
                     if (out_free) begin
                        q_pop          = 1'b1;
                        emit           = 1'b1;
                        emit_rsp.kind  = MSG_BEND;
                        emit_rsp.value = q_data.value;
                     end
                  end
                  OP_NOTE_OFF: begin
                     q_pop = 1'b1;
                     if (active_ff[q_pidx]) begin
                        st_in = ST_OFF;
                     end
                  end
                  OP_PRESSURE: begin
                     q_pop = 1'b1;
                     if (active_ff[q_pidx]) begin
                        st_in = ST_PRES;
                     end
                  end
                  OP_FLUSH: begin
                     q_pop = 1'b1;
                     if (head_ff != tail_ff) begin
                        cnt_in = '0;
                        st_in  = ST_FRD;
                     end
                  end
                  OP_ALL_OFF: begin
                     q_pop   = 1'b1;
                     head_in = '0;
                     tail_in = '0;
                     if (active_ff != '0) begin
                        st_in = ST_ARD;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_OFF: begin
            if (out_free) begin
               emit               = 1'b1;
               emit_rsp.note      = note_rd_ff;
               active_in[op_pidx] = 1'b0;
               st_in              = ST_IDLE;
            end
         end
         ST_PRES: begin
            if (at_pass) begin
               ring_we          = 1'b1;
               head_in          = head_next;
               pres_we          = 1'b1;
               pres_wdata       = new_pres;
               time_we          = 1'b1;
               seen_in[op_pidx] = 1'b1;
            end
            st_in = ST_IDLE;
         end
         ST_FRD: begin
            st_in = ST_FEMIT;
         end
         ST_FEMIT: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_rsp.kind  = MSG_AFTER;
               emit_rsp.note  = ring_rd_ff.note;
               emit_rsp.value = VALUE_W'(ring_rd_ff.pressure);
               emit_rsp.last  = flush_last;
               tail_in        = tail_next;
               cnt_in         = cnt_ff + 1'b1;
               st_in          = flush_last ? ST_IDLE : ST_FRD;
            end
         end
         ST_ARD: begin
            sel_in = first_idx;
            st_in  = ST_AEMIT;
         end
         ST_AEMIT: begin
            if (out_free) begin
               emit              = 1'b1;
               emit_rsp.note     = note_rd_ff;
               emit_rsp.last     = all_off_last;
               active_in[sel_ff] = 1'b0;
               st_in             = all_off_last ? ST_IDLE : ST_ARD;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      out_in       = emit ? emit_rsp : out_ff;
      out_valid_in = emit || (out_valid_ff && !rsp_ready);
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         active_ff    <= '0;
         seen_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         active_ff    <= active_in;
         seen_ff      <= seen_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      sel_ff <= sel_in;
      out_ff <= out_in;
   end

   // pad tables
   always_ff @(posedge clock) begin
      if (note_we) begin
         note_mem[wr_addr] <= note_wdata;
      end
      if (note_re) begin
         note_rd_ff <= note_mem[note_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pres_we) begin
         pres_mem[wr_addr] <= pres_wdata;
      end
      if (pad_re) begin
         pres_rd_ff <= pres_mem[q_pidx];
      end
   end

   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[wr_addr] <= op_ff.now;
      end
      if (pad_re) begin
         time_rd_ff <= time_mem[q_pidx];
         seen_rd_ff <= seen_ff[q_pidx];
      end
   end

   // aftertouch ring
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[head_ff] <= '{note: note_rd_ff, pressure: new_pres};
      end
      if (ring_re) begin
         ring_rd_ff <= ring_mem[tail_ff];
      end
   end

endmodule

// ----- rtl/core/pad_note_aftertouch_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_note_aftertouch_engine
// Per-pad note and polyphonic aftertouch message engine with a queued ring
// of aftertouch events.
// ----------------------------------------------------------------------------
// A request beat is taken into a two-entry operation queue, so the request
// side keeps flowing while the queue has room, even as the back end works or
// the response side stalls. The back end runs one operation at a time: note
// on and pitch bend are sent straight from the queue head, while note off and
// pressure updates first read the pad tables, which are memories with a
// registered read. Flush sends at most FLUSH_LIMIT queued events and all-off
// one message per active pad, each one-at-a-time through the single response
// register. No clearing pass follows reset: pad activity and the flags that
// mark valid timestamps are tracked in flip-flops. Configuration writes are
// taken in any cycle (csr_ready is always high) and should be made only while
// the engine is idle.
// ----------------------------------------------------------------------------
module pad_note_aftertouch_engine
   import pnae_pkg::*;
#(
   parameter int PAD_COUNT   = 32,
   parameter int RING_DEPTH  = 16,
   parameter int FLUSH_LIMIT = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   // request beats
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // pad[4:0], note_number[12:5], velocity[19:13], pressure[26:20],
   // bend_value[40:27], now_ms[72:41], zero fill above
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // command[2:0]
   input  logic [CMD_W-1:0]        req_tuser,
   // response beats
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // out_channel[3:0], out_note[10:4], out_value[24:11], zero fill above
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // msg_kind[1:0]
   output logic [KIND_W-1:0]       rsp_tuser,
   output logic                    rsp_tlast,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   cfg_type      cfg_ff, cfg_in;
   logic         q_push, q_pop, q_full, q_valid;
   op_entry_type q_entry, q_head;
   rsp_type      rsp;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MIDI_CHANNEL: cfg_in.channel  = csr_data[CHAN_W-1:0];
            REG_INTERVAL:     cfg_in.interval = csr_data[INTERVAL_W-1:0];
            REG_STEP_MIN:     cfg_in.step_min = csr_data[STEP_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel  <= CHANNEL_RESET;
         cfg_ff.interval <= INTERVAL_RESET;
         cfg_ff.step_min <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request decode
   pnae_front #(
      .PAD_COUNT (PAD_COUNT)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   // operation queue
   pnae_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head_data (q_head)
   );

   // execution and response register
   pnae_back #(
      .PAD_COUNT   (PAD_COUNT),
      .RING_DEPTH  (RING_DEPTH),
      .FLUSH_LIMIT (FLUSH_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp)
   );

   // response packing
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp.value, rsp.note, rsp.channel};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

// ----- rtl/core/pnae_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnae_checker
// Port-level checks on the response side of the engine, bound to the top.
// ----------------------------------------------------------------------------
module pnae_checker
   import pnae_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [KIND_W-1:0]      rsp_tuser,
   input  logic                   rsp_tlast
);

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response beat offered right after reset");

   // a stalled beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled response beat changed");

   // the unused message kind never appears
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == MSG_NOTE || rsp_tuser == MSG_AFTER
                      || rsp_tuser == MSG_BEND))
      else $error("response beat with unused message kind");

   // pitch bend carries no note and always ends its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == MSG_BEND |->
         rsp_tdata[10:4] == '0 && rsp_tlast)
      else $error("pitch bend beat with note or without last");

endmodule

bind pad_note_aftertouch_engine pnae_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pad note and aftertouch engine. A driver feeds
// request beats from a pending queue with random gaps. A built-in predictor
// keeps its own pad tables, aftertouch ring and register copies, and works out
// the MIDI messages of every accepted beat. A monitor stalls the response side
// at random and compares each response beat with the oldest predicted message.
// The run covers a directed opening, register settings at their extremes and
// random traffic that fills the ring and sweeps every pad.
// ----------------------------------------------------------------------------
module tb_top;
   import pnae_pkg::*;

   localparam int PADS         = 32;
   localparam int AT_FLUSH_MAX = 4;
   localparam int FILL_ITEMS   = 29;
   localparam int SWEEP_ITEMS  = PADS + 1;
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]     cmd;
      logic [PAD_W-1:0]     pad;
      logic [NOTE_IN_W-1:0] note;
      logic [VEL_W-1:0]     velocity;
      logic [PRES_W-1:0]    pressure;
      logic [BEND_W-1:0]    bend;
      logic [TIME_W-1:0]    now;
   } pad_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [CMD_W-1:0]       req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   pad_note_aftertouch_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state: register copies, pad tables and the aftertouch ring
   logic [CHAN_W-1:0]     cfg_channel;
   logic [INTERVAL_W-1:0] cfg_interval;
   logic [STEP_W-1:0]     cfg_step;
   logic [NOTE_IN_W-1:0]  note_of_pad [PADS];
   logic [PRES_W-1:0]     sent_pres [PADS];
   logic [TIME_W-1:0]     sent_time [PADS];
   ring_entry_type        at_ring [16];
   logic [3:0]            ring_wr;
   logic [3:0]            ring_rd;

   pad_event_type pad_events_pending [$];
   rsp_type       midi_due [$];

   int error_count    = 0;
   int items_accepted = 0;

   // stimulus shaping state
   logic [TIME_W-1:0] gen_ms;
   int                last_gen_pres [PADS];

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic void queue_msg(input logic [KIND_W-1:0] kind,
                                     input logic [NOTE_W-1:0] note,
                                     input logic [VALUE_W-1:0] value);
      rsp_type msg;
      msg.kind    = kind;
      msg.channel = cfg_channel;
      msg.note    = note;
      msg.value   = value;
      msg.last    = 1'b0;
      midi_due.push_back(msg);
   endfunction

   // messages caused by one accepted request beat
   function automatic void predict_midi(input pad_event_type ev);
      int             n;
      int             delta;
      logic [31:0]    elapsed;
      logic [3:0]     next_wr;
      ring_entry_type slot;
      rsp_type        tail_msg;
      n = 0;
      case (ev.cmd)
         CMD_NOTE_ON: begin
            if (ev.note != NOTE_NONE) begin
               note_of_pad[ev.pad] = ev.note;
               sent_pres[ev.pad]   = '0;
               queue_msg(MSG_NOTE, ev.note[NOTE_W-1:0], VALUE_W'(ev.velocity));
               n++;
            end
         end
         CMD_NOTE_OFF: begin
            if (note_of_pad[ev.pad] != NOTE_NONE) begin
               queue_msg(MSG_NOTE, note_of_pad[ev.pad][NOTE_W-1:0], '0);
               n++;
               note_of_pad[ev.pad] = NOTE_NONE;
               sent_pres[ev.pad]   = '0;
            end
         end
         CMD_PRESSURE: begin
            if (note_of_pad[ev.pad] != NOTE_NONE) begin
               delta   = int'(ev.pressure) - int'(sent_pres[ev.pad]);
               delta   = (delta < 0) ? -delta : delta;
               elapsed = ev.now - sent_time[ev.pad];
               next_wr = ring_wr + 4'd1;
               if (delta >= int'(cfg_step) && elapsed >= 32'(cfg_interval)
                   && next_wr != ring_rd) begin
                  slot.note       = note_of_pad[ev.pad][NOTE_W-1:0];
                  slot.pressure   = ev.pressure;
                  at_ring[ring_wr] = slot;
                  ring_wr          = next_wr;
                  sent_pres[ev.pad] = ev.pressure;
                  sent_time[ev.pad] = ev.now;
               end
            end
         end
         CMD_FLUSH: begin
            while (ring_rd != ring_wr && n < AT_FLUSH_MAX) begin
               queue_msg(MSG_AFTER, at_ring[ring_rd].note,
                         VALUE_W'(at_ring[ring_rd].pressure));
               n++;
               ring_rd = ring_rd + 4'd1;
            end
         end
         CMD_ALL_OFF: begin
            for (int i = 0; i < PADS; i++) begin
               if (note_of_pad[i] != NOTE_NONE) begin
                  queue_msg(MSG_NOTE, note_of_pad[i][NOTE_W-1:0], '0);
                  n++;
                  note_of_pad[i] = NOTE_NONE;
                  sent_pres[i]   = '0;
               end
            end
            ring_wr = '0;
            ring_rd = '0;
         end
         CMD_BEND: begin
            queue_msg(MSG_BEND, '0, VALUE_W'(ev.bend));
            n++;
         end
         default: begin
         end
      endcase
      // flag the final message of this beat
      if (n > 0) begin
         tail_msg      = midi_due.pop_back();
         tail_msg.last = 1'b1;
         midi_due.push_back(tail_msg);
      end
   endfunction

   // request driver
   pad_event_type bus_event;
   logic          item_on_bus = 1'b0;
   int            feed_gap    = 0;
   int            feed_calm   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_midi(bus_event);
            if (bus_event.cmd <= CMD_BEND) items_accepted++;
            item_on_bus = 1'b0;
            if (feed_calm > 0) feed_calm--;
            else if ($urandom_range(0, 31) == 0) feed_calm = $urandom_range(20, 60);
            else feed_gap = pick_gap();
         end
         if (!item_on_bus) begin
            if (feed_gap > 0) begin
               feed_gap--;
            end else if (pad_events_pending.size() > 0) begin
               bus_event   = pad_events_pending.pop_front();
               item_on_bus = 1'b1;
               req_tdata <= {7'b0, bus_event.now, bus_event.bend, bus_event.pressure,
                             bus_event.velocity, bus_event.note, bus_event.pad};
               req_tuser <= bus_event.cmd;
            end
         end
         req_tvalid <= item_on_bus;
      end
   end

   // response monitor and back-pressure
   rsp_type got_msg;
   rsp_type want_msg;
   int      drain_stall     = 0;
   int      drain_calm      = 0;
   int      hold_left       = 0;
   logic    long_hold_done  = 1'b0;
   logic    ready_next;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_msg.kind    = rsp_tuser;
            got_msg.channel = rsp_tdata[3:0];
            got_msg.note    = rsp_tdata[10:4];
            got_msg.value   = rsp_tdata[24:11];
            got_msg.last    = rsp_tlast;
            if (midi_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat kind %0d note %0d value %0d",
                                         got_msg.kind, got_msg.note, got_msg.value));
            end else begin
               want_msg = midi_due.pop_front();
               if (got_msg.kind != want_msg.kind)
                  report_mismatch($sformatf("msg_kind %0d, want %0d",
                                            got_msg.kind, want_msg.kind));
               if (got_msg.channel != want_msg.channel)
                  report_mismatch($sformatf("out_channel %0d, want %0d",
                                            got_msg.channel, want_msg.channel));
               if (got_msg.note != want_msg.note)
                  report_mismatch($sformatf("out_note %0d, want %0d",
                                            got_msg.note, want_msg.note));
               if (got_msg.value != want_msg.value)
                  report_mismatch($sformatf("out_value %0d, want %0d",
                                            got_msg.value, want_msg.value));
               if (got_msg.last != want_msg.last)
                  report_mismatch($sformatf("last_of_run %0b, want %0b",
                                            got_msg.last, want_msg.last));
            end
         end
         // one long hold-off mid run, otherwise short random stalls
         ready_next = 1'b1;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!long_hold_done && items_accepted >= 75) begin
            long_hold_done = 1'b1;
            hold_left      = 400;
            ready_next     = 1'b0;
         end else if (drain_stall > 0) begin
            drain_stall--;
            ready_next = 1'b0;
         end else if (drain_calm > 0) begin
            drain_calm--;
         end else if ($urandom_range(0, 63) == 0) begin
            drain_calm = $urandom_range(30, 80);
         end else begin
            drain_stall = pick_gap();
         end
         rsp_tready <= ready_next;
      end
   end

   // stimulus helpers
   function automatic pad_event_type make_event(input logic [CMD_W-1:0] cmd, input int pad,
                                                input int note, input int amount,
                                                input logic [TIME_W-1:0] stamp);
      pad_event_type ev;
      ev.cmd      = cmd;
      ev.pad      = PAD_W'(pad);
      ev.note     = NOTE_IN_W'(note);
      ev.velocity = VEL_W'($urandom);
      ev.pressure = PRES_W'($urandom);
      ev.bend     = BEND_W'($urandom);
      ev.now      = stamp;
      case (cmd)
         CMD_NOTE_ON:  ev.velocity = VEL_W'(amount);
         CMD_PRESSURE: ev.pressure = PRES_W'(amount);
         CMD_BEND:     ev.bend     = BEND_W'(amount);
         default: begin
         end
      endcase
      return ev;
   endfunction

   // activate four pads, swing their pressure until the ring overflows, then drain
   task automatic queue_ring_fill();
      for (int k = 0; k < 4; k++)
         pad_events_pending.push_back(make_event(CMD_NOTE_ON, k, $urandom_range(0, 254),
                                                 $urandom_range(0, 127), $urandom));
      for (int k = 0; k < 20; k++) begin
         gen_ms += 300;
         pad_events_pending.push_back(make_event(CMD_PRESSURE, k % 4, $urandom_range(0, 255),
                                                 ((k / 4) % 2 == 1) ? 0 : 127, gen_ms));
      end
      for (int k = 0; k < 5; k++)
         pad_events_pending.push_back(make_event(CMD_FLUSH, $urandom_range(0, 31),
                                                 $urandom_range(0, 255), 0, $urandom));
   endtask

   // every pad sounding, then all off for the largest burst
   task automatic queue_pad_sweep();
      for (int k = 0; k < PADS; k++)
         pad_events_pending.push_back(make_event(CMD_NOTE_ON, k, $urandom_range(0, 254),
                                                 $urandom_range(0, 127), $urandom));
      pad_events_pending.push_back(make_event(CMD_ALL_OFF, $urandom_range(0, 31),
                                              $urandom_range(0, 255), 0, $urandom));
   endtask

   task automatic queue_random_items(input int count, input bit fill_first,
                                     input bit sweep_first);
      int made;
      int r;
      int pad;
      int note;
      int pres;
      int span;
      made = 0;
      gen_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 200) : $urandom;
      if (fill_first) begin
         queue_ring_fill();
         made += FILL_ITEMS;
      end
      if (sweep_first) begin
         queue_pad_sweep();
         made += SWEEP_ITEMS;
      end
      while (made < count) begin
         pad = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
         r   = $urandom_range(0, 99);
         if (r < 3) begin
            queue_ring_fill();
            made += FILL_ITEMS;
         end else if (r < 4) begin
            queue_pad_sweep();
            made += SWEEP_ITEMS;
         end else if (r < 28) begin
            r    = $urandom_range(0, 19);
            note = (r == 0) ? 255 : (r < 3) ? $urandom_range(128, 254) : $urandom_range(0, 127);
            pad_events_pending.push_back(make_event(CMD_NOTE_ON, pad, note,
                                                    $urandom_range(0, 127), $urandom));
            made++;
         end else if (r < 36) begin
            pad_events_pending.push_back(make_event(CMD_NOTE_OFF, pad, $urandom_range(0, 255),
                                                    0, $urandom));
            made++;
         end else if (r < 66) begin
            // pressure: mostly near the last value so the threshold is probed
            gen_ms += ($urandom_range(0, 9) == 0) ? $urandom
                                                  : $urandom_range(0, 2 * cfg_interval + 2);
            span = int'(cfg_step) + 1;
            if ($urandom_range(0, 2) == 0) pres = $urandom_range(0, 127);
            else pres = last_gen_pres[pad] + $urandom_range(0, 2 * span) - span;
            if (pres < 0) pres = 0;
            if (pres > 127) pres = 127;
            last_gen_pres[pad] = pres;
            pad_events_pending.push_back(make_event(CMD_PRESSURE, pad, $urandom_range(0, 255),
                                                    pres, gen_ms));
            made++;
         end else if (r < 80) begin
            pad_events_pending.push_back(make_event(CMD_FLUSH, pad, $urandom_range(0, 255),
                                                    0, $urandom));
            made++;
         end else if (r < 90) begin
            pad_events_pending.push_back(make_event(CMD_BEND, pad, $urandom_range(0, 255),
                                                    $urandom_range(0, 16383), $urandom));
            made++;
         end else if (r < 94) begin
            pad_events_pending.push_back(make_event(CMD_ALL_OFF, pad, $urandom_range(0, 255),
                                                    0, $urandom));
            made++;
         end else begin
            pad_events_pending.push_back(make_event(($urandom_range(0, 1) == 1) ? CMD_SPARE_HI
                                                    : CMD_SPARE_LO, pad,
                                                    $urandom_range(0, 255), 0, $urandom));
            made++;
         end
      end
   endtask

   // wait until every beat is in and every message is out, then let the back end go quiet
   task automatic settle();
      do @(negedge clock);
      while (pad_events_pending.size() != 0 || item_on_bus || midi_due.size() != 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      case (idx)
         REG_MIDI_CHANNEL: cfg_channel  = CHAN_W'(value);
         REG_INTERVAL:     cfg_interval = INTERVAL_W'(value);
         REG_STEP_MIN:     cfg_step     = STEP_W'(value);
         default: begin
         end
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int channel, input int interval, input int step);
      write_reg(REG_MIDI_CHANNEL, channel);
      write_reg(REG_INTERVAL, interval);
      write_reg(REG_STEP_MIN, step);
   endtask

   // run limit
   initial begin
      #(20_000_000);
      $display("simulation failed");
      $finish;
   end

   // main sequence
   initial begin
      cfg_channel  = CHANNEL_RESET;
      cfg_interval = INTERVAL_RESET;
      cfg_step     = STEP_RESET;
      for (int i = 0; i < PADS; i++) begin
         note_of_pad[i]   = NOTE_NONE;
         sent_pres[i]     = '0;
         sent_time[i]     = '0;
         last_gen_pres[i] = 0;
      end
      ring_wr = '0;
      ring_rd = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed opening at reset register values
      pad_events_pending.push_back(make_event(CMD_BEND, 3, 0, 0, $urandom));
      pad_events_pending.push_back(make_event(CMD_BEND, 28, 255, 16383, $urandom));
      pad_events_pending.push_back(make_event(CMD_NOTE_ON, 0, 0, 0, $urandom));
      pad_events_pending.push_back(make_event(CMD_NOTE_ON, 31, 127, 127, $urandom));
      // note above 127 keeps its low seven bits on the wire
      pad_events_pending.push_back(make_event(CMD_NOTE_ON, 5, 200, 64, $urandom));
      // unmapped note is dropped
      pad_events_pending.push_back(make_event(CMD_NOTE_ON, 7, 255, 90, $urandom));
      pad_events_pending.push_back(make_event(CMD_PRESSURE, 0, 17, 127, 32'd100));
      // change below the step
      pad_events_pending.push_back(make_event(CMD_PRESSURE, 31, 1, 2, 32'd101));
      // idle pad
      pad_events_pending.push_back(make_event(CMD_PRESSURE, 9, 44, 90, 32'd102));
      pad_events_pending.push_back(make_event(CMD_PRESSURE, 5, 0, 10, 32'hFFFF_FFFF));
      // timestamp wrap: too soon, then late enough
      pad_events_pending.push_back(make_event(CMD_PRESSURE, 5, 0, 60, 32'd3));
      pad_events_pending.push_back(make_event(CMD_PRESSURE, 5, 0, 60, 32'd40));
      pad_events_pending.push_back(make_event(CMD_PRESSURE, 0, 0, 0, 32'd110));
      // note on an active pad replaces the note and clears the pressure
      pad_events_pending.push_back(make_event(CMD_NOTE_ON, 0, 50, 100, $urandom));
      // exactly on both thresholds
      pad_events_pending.push_back(make_event(CMD_PRESSURE, 0, 0, 4, 32'd125));
      pad_events_pending.push_back(make_event(CMD_PRESSURE, 31, 0, 127, 32'd500));
      // five queued events: full batch, remainder, then empty ring
      pad_events_pending.push_back(make_event(CMD_FLUSH, 1, 0, 0, $urandom));
      pad_events_pending.push_back(make_event(CMD_FLUSH, 2, 0, 0, $urandom));
      pad_events_pending.push_back(make_event(CMD_FLUSH, 4, 0, 0, $urandom));
      pad_events_pending.push_back(make_event(CMD_NOTE_OFF, 31, 0, 0, $urandom));
      pad_events_pending.push_back(make_event(CMD_NOTE_OFF, 31, 0, 0, $urandom));
      pad_events_pending.push_back(make_event(CMD_SPARE_LO, 6, 33, 0, $urandom));
      pad_events_pending.push_back(make_event(CMD_SPARE_HI, 25, 222, 0, $urandom));
      pad_events_pending.push_back(make_event(CMD_ALL_OFF, 0, 0, 0, $urandom));
      pad_events_pending.push_back(make_event(CMD_ALL_OFF, 17, 0, 0, $urandom));
      settle();

      // random phases across register settings
      set_config(15, 1, 1);
      queue_random_items(35, 1'b1, 1'b0);
      settle();
      set_config(0, 255, 127);
      queue_random_items(35, 1'b1, 1'b0);
      settle();
      set_config($urandom_range(0, 15), $urandom_range(1, 255), $urandom_range(1, 127));
      queue_random_items(40, 1'b0, 1'b1);
      settle();
      set_config($urandom_range(0, 15), 25, 4);
      queue_random_items(20, 1'b0, 1'b0);
      settle();

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/pnae_pkg.sv
rtl/core/pnae_front.sv
rtl/core/pnae_fifo.sv
rtl/core/pnae_back.sv
rtl/core/pad_note_aftertouch_engine.sv
rtl/core/pnae_checker.sv
tb/tb_top.sv
